// ----- rtl/sync_length_sum8_frame_parser_top_macros.svh -----
// Assertion macros used by the frame parser checker.
`ifndef SYNC_LENGTH_SUM8_FRAME_PARSER_TOP_MACROS_SVH
`define SYNC_LENGTH_SUM8_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfp_pkg.sv -----
// Types and constants shared by the sync/length/sum8 frame parser.
package sfp_pkg;

    localparam int BYTE_W = 8;
    localparam int CMD_W  = 16;
    localparam int LEN_W  = 10;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
    // Running sum after both sync bytes: (0x55 + 0xAA) mod 256
    localparam logic [BYTE_W-1:0] SYNC_SUM    = 8'hFF;
    localparam logic [LEN_W-1:0]  HARD_LIMIT  = 10'd512;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  payload_length;
        logic              first_of_frame;
        logic              end_of_frame;
        t_status           frame_status;
    } t_result;

endpackage

// ----- rtl/sfp_rx_if.sv -----
// Received-byte channel: valid/ready handshake carrying one byte.
interface sfp_rx_if
    import sfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
    modport mon    (input valid, input rx_byte, input ready);
endinterface

// ----- rtl/sfp_res_if.sv -----
// Result channel: valid/ready handshake carrying one parser result.
interface sfp_res_if
    import sfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  payload_length;
    logic              first_of_frame;
    logic              end_of_frame;
    logic [1:0]        frame_status;

    modport source (output valid, output payload_byte, output command,
                    output payload_length, output first_of_frame,
                    output end_of_frame, output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input command,
                    input payload_length, input first_of_frame,
                    input end_of_frame, input frame_status, output ready);
    modport mon    (input valid, input payload_byte, input command,
                    input payload_length, input first_of_frame,
                    input end_of_frame, input frame_status, input ready);
endinterface

// ----- rtl/sfp_fsm.sv -----
// Frame parser state machine: sync hunt, header, payload and checksum.
module sfp_fsm
    import sfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_acc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_CMD_HI,
        PH_CMD_LO,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [LEN_W-1:0]  r_rem,    n_rem;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic [CMD_W-1:0]  r_cmd,    n_cmd;
    logic              r_first,  n_first;
    logic [LEN_W-1:0]  r_max;

    logic [LEN_W-1:0]    w_limit;
    logic [2*BYTE_W-1:0] w_len_full;
    logic [BYTE_W-1:0]   w_sum_add;

    // Clamp the limit register to the hard ceiling
    assign w_limit    = (r_max > HARD_LIMIT) ? HARD_LIMIT : r_max;
    assign w_len_full = {r_len_hi, i_byte};
    assign w_sum_add  = r_sum + i_byte;

    // Next state and result for the byte in this transfer
    always_comb begin
        n_phase  = r_phase;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_rem    = r_rem;
        n_sum    = r_sum;
        n_cmd    = r_cmd;
        n_first  = r_first;

        o_res_valid          = 1'b0;
        o_res.payload_byte   = '0;
        o_res.command        = r_cmd;
        o_res.payload_length = r_len;
        o_res.first_of_frame = r_first;
        o_res.end_of_frame   = 1'b0;
        o_res.frame_status   = ST_PAYLOAD;

        if (i_acc) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_phase = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase = PH_LEN_HI;
                        n_sum   = SYNC_SUM;
                        n_len   = '0;
                        n_cmd   = '0;
                        n_first = 1'b1;
                    end else if (i_byte == SYNC_FIRST) begin
                        n_phase = PH_HUNT2;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_sum    = w_sum_add;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    // Drop an oversized frame and resume the hunt
                    if (w_len_full > {{(2*BYTE_W-LEN_W){1'b0}}, w_limit}) begin
                        n_phase = PH_HUNT1;
                        n_len   = '0;
                        n_sum   = '0;
                    end else begin
                        n_len   = w_len_full[LEN_W-1:0];
                        n_rem   = w_len_full[LEN_W-1:0];
                        n_sum   = w_sum_add;
                        n_phase = PH_CMD_HI;
                    end
                end
                PH_CMD_HI: begin
                    n_cmd   = {i_byte, {BYTE_W{1'b0}}};
                    n_sum   = w_sum_add;
                    n_phase = PH_CMD_LO;
                end
                PH_CMD_LO: begin
                    n_cmd[BYTE_W-1:0] = i_byte;
                    n_sum   = w_sum_add;
                    n_phase = (r_rem == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                    n_sum   = w_sum_add;
                    n_first = 1'b0;
                    n_rem   = r_rem - 1'b1;
                    if (r_rem == LEN_W'(1)) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_res_valid        = 1'b1;
                    o_res.end_of_frame = 1'b1;
                    o_res.frame_status = (i_byte == r_sum) ? ST_GOOD : ST_BAD;
                    n_first = 1'b0;
                    n_sum   = '0;
                    n_rem   = '0;
                    n_phase = PH_HUNT1;
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    // Hold parser state and the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_len_hi <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_sum    <= '0;
            r_cmd    <= '0;
            r_first  <= 1'b1;
            r_max    <= HARD_LIMIT;
        end else begin
            r_phase  <= n_phase;
            r_len_hi <= n_len_hi;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_sum    <= n_sum;
            r_cmd    <= n_cmd;
            r_first  <= n_first;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/sync_length_sum8_frame_parser_top.sv -----
// A result appears in the output register in the cycle after its byte transfer.
// Throughput: one byte per cycle; the input takes a byte whenever the output
//   register is empty or is being drained in the same cycle.
// Bytes of the sync, length and command fields produce no result.
// Reset (synchronous, active low) empties the output register, returns the
//   parser to the sync hunt and sets max_payload to 512.
module sync_length_sum8_frame_parser_top
    import sfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    sfp_rx_if.sink           i_rx,
    sfp_res_if.source        o_res
);

    logic    w_acc;
    logic    w_res_valid;
    t_result w_res;
    logic    r_out_valid;
    t_result r_out;

    // Take a byte when the output register can accept a new result
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_acc      = i_rx.valid && i_rx.ready;

    sfp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (w_acc),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Load a new result, drop the old one on transfer, else hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= w_res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.command        = r_out.command;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.first_of_frame = r_out.first_of_frame;
    assign o_res.end_of_frame   = r_out.end_of_frame;
    assign o_res.frame_status   = r_out.frame_status;

endmodule

// ----- rtl/sfp_checker.sv -----
// Port-level checker for the frame parser, bound to the top level.
`include "sync_length_sum8_frame_parser_top_macros.svh"

module sfp_checker
    import sfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rx_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [BYTE_W-1:0] i_res_payload_byte,
    input logic [LEN_W-1:0]  i_res_payload_length,
    input logic              i_res_end_of_frame,
    input logic [1:0]        i_res_frame_status
);

    logic w_end_ok;
    logic w_pay_ok;

    // End results carry a checksum verdict and no data byte
    assign w_end_ok = (i_res_frame_status == ST_GOOD || i_res_frame_status == ST_BAD)
                      && (i_res_payload_byte == '0);
    // Payload results carry the payload code and a legal length
    assign w_pay_ok = (i_res_frame_status == ST_PAYLOAD)
                      && (i_res_payload_length != '0)
                      && (i_res_payload_length <= HARD_LIMIT);

    `SFP_ASSERT_IMP(a_end_status, i_clk, i_rst_n, i_res_valid && i_res_end_of_frame,
        w_end_ok, "end result has bad status or data")
    `SFP_ASSERT_IMP(a_pay_status, i_clk, i_rst_n, i_res_valid && !i_res_end_of_frame,
        w_pay_ok, "payload result has bad status or length")
    `SFP_ASSERT_IMP(a_rx_stall, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        !i_rx_ready, "byte taken while result is stalled")
    `SFP_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_payload_byte) && $stable(i_res_frame_status),
        "stalled result changed")

endmodule

bind sync_length_sum8_frame_parser_top sfp_checker u_sfp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_rx_ready           (i_rx.ready),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_payload_byte   (o_res.payload_byte),
    .i_res_payload_length (o_res.payload_length),
    .i_res_end_of_frame   (o_res.end_of_frame),
    .i_res_frame_status   (o_res.frame_status)
);

// ----- tb/sv/tb_sync_length_sum8_frame_parser_top.sv -----
// Self-checking testbench for the sync/length/sum8 frame parser top level.
`timescale 1ns / 100ps

module tb_sync_length_sum8_frame_parser_top;
    import sfp_pkg::*;

    localparam int DRAIN_MARK  = -1;   // queue entry: hold the sender until results drain
    localparam int QUIET_LIMIT = 2000; // cycles without any transfer before giving up
    localparam int PHASE_BYTES = 100;

    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        READ_LEN_HI,
        READ_LEN_LO,
        READ_CMD_HI,
        READ_CMD_LO,
        READ_PAYLOAD,
        READ_CHECKSUM
    } t_parse_state;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_data;

    sfp_rx_if  rx_if ();
    sfp_res_if res_if ();

    sync_length_sum8_frame_parser_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    always #2 i_clk = ~i_clk;

    // Byte stream still to be sent, and frame results still to be seen
    int      rx_stream[$];
    t_result predicted_results[$];
    int      queued_bytes = 0;

    // Shadow of the parser state and of the max_payload register
    t_parse_state     parse_state   = SEEK_FIRST;
    logic [15:0]      frame_length  = '0;
    logic [LEN_W-1:0] payload_left  = '0;
    logic [7:0]       frame_sum     = '0;
    logic [15:0]      frame_command = '0;
    logic             frame_opening = 1'b1;
    logic [LEN_W-1:0] limit_reg     = HARD_LIMIT;

    // Run statistics
    int errors = 0;
    int reports = 0;
    int good_frames = 0;
    int bad_frames = 0;
    int dropped_frames = 0;
    int payload_seen = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int limits_written = 0;

    // Sender and receiver pacing
    bit          hold_for_results = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          next_item;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;
    int          quiet_cycles = 0;

    // Advance the shadow parser by one byte; return 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        logic [LEN_W-1:0] lim;
        bit               has_result;
        lim = (limit_reg < HARD_LIMIT) ? limit_reg : HARD_LIMIT;
        has_result = 1'b0;
        res = '0;
        case (parse_state)
            SEEK_FIRST: begin
                if (b == SYNC_FIRST)
                    parse_state = SEEK_SECOND;
            end
            SEEK_SECOND: begin
                if (b == SYNC_SECOND) begin
                    parse_state   = READ_LEN_HI;
                    frame_sum     = SYNC_SUM;
                    frame_length  = '0;
                    frame_command = '0;
                    frame_opening = 1'b1;
                end else begin
                    parse_state = (b == SYNC_FIRST) ? SEEK_SECOND : SEEK_FIRST;
                end
            end
            READ_LEN_HI: begin
                frame_length = {b, 8'h00};
                frame_sum    = frame_sum + b;
                parse_state  = READ_LEN_LO;
            end
            READ_LEN_LO: begin
                frame_length[7:0] = b;
                frame_sum         = frame_sum + b;
                if (frame_length > lim) begin
                    // drop the frame and hunt again from the next byte
                    parse_state  = SEEK_FIRST;
                    frame_length = '0;
                    frame_sum    = '0;
                    dropped_frames++;
                end else begin
                    payload_left = frame_length[LEN_W-1:0];
                    parse_state  = READ_CMD_HI;
                end
            end
            READ_CMD_HI: begin
                frame_command = {b, 8'h00};
                frame_sum     = frame_sum + b;
                parse_state   = READ_CMD_LO;
            end
            READ_CMD_LO: begin
                frame_command[7:0] = b;
                frame_sum          = frame_sum + b;
                parse_state = (payload_left == 0) ? READ_CHECKSUM : READ_PAYLOAD;
            end
            READ_PAYLOAD: begin
                frame_sum          = frame_sum + b;
                res.payload_byte   = b;
                res.end_of_frame   = 1'b0;
                res.frame_status   = ST_PAYLOAD;
                has_result         = 1'b1;
                payload_left       = payload_left - 1'b1;
                payload_seen++;
                if (payload_left == 0)
                    parse_state = READ_CHECKSUM;
            end
            default: begin
                res.payload_byte = '0;
                res.end_of_frame = 1'b1;
                res.frame_status = (b == frame_sum) ? ST_GOOD : ST_BAD;
                if (b == frame_sum)
                    good_frames++;
                else
                    bad_frames++;
                has_result   = 1'b1;
                parse_state  = SEEK_FIRST;
                frame_sum    = '0;
                payload_left = '0;
            end
        endcase
        if (has_result) begin
            res.command        = frame_command;
            res.payload_length = frame_length[LEN_W-1:0];
            res.first_of_frame = frame_opening;
            frame_opening      = 1'b0;
        end
        return has_result;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        rx_stream.push_back(int'(b));
        queued_bytes++;
    endfunction

    // Queue one complete frame, optionally with a corrupted checksum byte
    function automatic void queue_frame(input int len, input logic [15:0] cmd,
                                        input bit corrupt);
        logic [15:0] len16;
        logic [7:0]  chk;
        logic [7:0]  pb;
        len16 = len[15:0];
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(len16[15:8]);
        push_byte(len16[7:0]);
        push_byte(cmd[15:8]);
        push_byte(cmd[7:0]);
        chk = SYNC_SUM + len16[15:8] + len16[7:0] + cmd[15:8] + cmd[7:0];
        for (int i = 0; i < len; i++) begin
            pb  = 8'($urandom_range(0, 255));
            push_byte(pb);
            chk = chk + pb;
        end
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        push_byte(chk);
    endfunction

    // Queue a header whose length exceeds the limit; the parser drops it
    function automatic void queue_oversize(input int len);
        logic [15:0] len16;
        len16 = len[15:0];
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(len16[15:8]);
        push_byte(len16[7:0]);
    endfunction

    // Mostly good frames; else corrupt checksums, oversized headers, noise, broken syncs
    task automatic random_traffic(input int budget);
        int          stop_at;
        int          lim;
        int          len;
        int          roll;
        logic [7:0]  b;
        lim = (limit_reg < HARD_LIMIT) ? int'(limit_reg) : int'(HARD_LIMIT);
        stop_at = queued_bytes + budget;
        while (queued_bytes < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(0, (lim < 40) ? lim : 40);
            else
                len = $urandom_range(0, (lim < 8) ? lim : 8);
            if (lim <= 64 && $urandom_range(0, 19) == 0)
                len = lim;
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
                queue_frame(len, 16'($urandom_range(0, 65535)), 1'b0);
            end else if (roll < 74) begin
                queue_frame(len, 16'($urandom_range(0, 65535)), 1'b1);
            end else if (roll < 84) begin
                queue_oversize($urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535));
            end else if (roll < 94) begin
                repeat ($urandom_range(1, 6)) begin
                    b = ($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
                    push_byte(b);
                end
            end else begin
                // broken sync: first sync byte, then anything but the second
                push_byte(SYNC_FIRST);
                if ($urandom_range(0, 1)) begin
                    push_byte(SYNC_FIRST);
                end else begin
                    b = 8'($urandom_range(0, 254));
                    if (b >= SYNC_SECOND)
                        b = b + 1'b1;
                    push_byte(b);
                end
            end
            if ($urandom_range(0, 99) < 3)
                rx_stream.push_back(DRAIN_MARK);
        end
    endtask

    // Wait until every byte is sent and every result has come, then let the tail pass
    task automatic wait_idle(input int tail);
        do begin
            @(posedge i_clk);
            #1;
        end while (rx_stream.size() != 0 || rx_if.valid || hold_for_results ||
                   predicted_results.size() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_reg = value;
        limits_written++;
    endtask

    // Sender: drain the byte queue in bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
        end else if (rx_if.valid && !rx_if.ready) begin
            // hold the byte until the transfer completes
        end else if (hold_for_results) begin
            rx_if.valid <= 1'b0;
            if (predicted_results.size() == 0)
                hold_for_results = 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            rx_if.valid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
            next_item = rx_stream.pop_front();
            if (next_item == DRAIN_MARK) begin
                hold_for_results = 1'b1;
                rx_if.valid <= 1'b0;
            end else begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= next_item[7:0];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end else begin
            rx_if.valid <= 1'b0;
        end
    end

    // Receiver: stall on a rotating pattern, reshuffled every so often
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 4))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                2: stall_pattern = 16'h5555;
                3: stall_pattern = 16'h0001;
                default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
            endcase
            pattern_age = $urandom_range(20, 80);
        end else begin
            pattern_age--;
        end
        res_if.ready  <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end

    // Monitor: check result transfers, then predict from byte transfers
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_result res;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                results_checked++;
                got.payload_byte   = res_if.payload_byte;
                got.command        = res_if.command;
                got.payload_length = res_if.payload_length;
                got.first_of_frame = res_if.first_of_frame;
                got.end_of_frame   = res_if.end_of_frame;
                got.frame_status   = t_status'(res_if.frame_status);
                if (predicted_results.size() == 0) begin
                    errors++;
                    if (reports < 10) begin
                        reports++;
                        $display("%0t: unexpected result byte=%02h cmd=%04h len=%0d",
                                 $time, got.payload_byte, got.command, got.payload_length);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    if (got.payload_byte !== want.payload_byte ||
                        got.command !== want.command ||
                        got.payload_length !== want.payload_length ||
                        got.first_of_frame !== want.first_of_frame ||
                        got.end_of_frame !== want.end_of_frame ||
                        got.frame_status !== want.frame_status) begin
                        errors++;
                        if (reports < 10) begin
                            reports++;
                            $display("%0t: want byte=%02h cmd=%04h len=%0d first=%0b end=%0b st=%0d",
                                     $time, want.payload_byte, want.command,
                                     want.payload_length, want.first_of_frame,
                                     want.end_of_frame, want.frame_status);
                            $display("%0t:  got byte=%02h cmd=%04h len=%0d first=%0b end=%0b st=%0d",
                                     $time, got.payload_byte, got.command,
                                     got.payload_length, got.first_of_frame,
                                     got.end_of_frame, got.frame_status);
                        end
                    end
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                bytes_sent++;
                if (parse_byte(rx_if.rx_byte, res))
                    predicted_results.push_back(res);
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d results still expected", predicted_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset: assert at time zero, then release for good
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stimulus: directed frames first, then random traffic under several limits
    initial begin : stimulus
        logic [LEN_W-1:0] limits[6];
        limits = '{10'd0, 10'd1023, 10'd6, 10'd513, 10'd33, 10'd512};
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;

        // empty payload with an all-ones command: end result also opens the frame
        queue_frame(0, 16'hFFFF, 1'b0);
        // pause the sender until that result has come back
        rx_stream.push_back(DRAIN_MARK);
        // broken sync, then a repeated first sync byte ahead of a real frame
        push_byte(SYNC_FIRST);
        push_byte(8'h12);
        push_byte(SYNC_FIRST);
        queue_frame(1, 16'h0000, 1'b1);
        // one past the hard limit: dropped without a result
        queue_oversize(int'(HARD_LIMIT) + 1);
        wait_idle(4);

        foreach (limits[i]) begin
            write_limit(limits[i]);
            if (limits[i] > HARD_LIMIT) begin
                // a register above the hard limit still caps at it
                queue_frame(int'(HARD_LIMIT), 16'($urandom_range(0, 65535)), 1'b0);
                queue_oversize(int'(HARD_LIMIT) + 1);
            end
            random_traffic(PHASE_BYTES);
            wait_idle(4);
        end

        wait_idle(8);
        if (predicted_results.size() != 0) begin
            errors += predicted_results.size();
            $display("%0d results never arrived", predicted_results.size());
        end
        $display("Sent %0d bytes under %0d limit settings; checked %0d results.",
                 bytes_sent, limits_written, results_checked);
        $display("Frames: %0d good, %0d bad checksum, %0d dropped; %0d payload bytes; %0d errors.",
                 good_frames, bad_frames, dropped_frames, payload_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
